// ===== hw/rtl/go_to_goal_steering_core_defines.svh =====
// Assertion macros used by the checker file of go_to_goal_steering_core.
// Holds macro definitions only; no dependencies.
`ifndef GO_TO_GOAL_STEERING_CORE_DEFINES_SVH
`define GO_TO_GOAL_STEERING_CORE_DEFINES_SVH

// Same-cycle implication, switched off while reset is asserted.
`define GTG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define GTG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define GTG_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/gtg_pkg.sv =====
// Package for the go-to-goal steering core: widths, fixed-point constants,
// the arctangent table and the pipeline payload types. No dependencies.
package gtg_pkg;

    localparam int XY_W       = 28;  // CORDIC x/y: Q7.8 difference with 8 guard bits
    localparam int Z_W        = 24;  // CORDIC angle accumulator, radians Q.20
    localparam int HD_W       = 15;  // heading, Q3.12
    localparam int BEAR_W     = Z_W - 8;
    localparam int MAX_STAGES = 24;

    localparam logic signed [Z_W-1:0] ANG_PI_Q20   = 24'sd3294198;
    localparam logic signed [17:0]    INV_GAIN_Q16 = 18'sd39797;
    localparam int                    PI_Q12       = 12868;
    localparam int                    TWO_PI_Q12   = 25736;

    typedef enum logic [2:0] {
        REG_GOAL_X           = 3'd0,
        REG_GOAL_Y           = 3'd1,
        REG_ARRIVE_TOLERANCE = 3'd2,
        REG_TURN_GAIN        = 3'd3,
        REG_TURN_LIMIT       = 3'd4,
        REG_DRIVE_GAIN       = 3'd5,
        REG_DRIVE_LIMIT      = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic signed [15:0] goal_x;
        logic signed [15:0] goal_y;
        logic [14:0]        arrive_tolerance;
        logic [11:0]        turn_gain;
        logic [13:0]        turn_limit;
        logic [11:0]        drive_gain;
        logic [14:0]        drive_limit;
    } cfg_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic signed [HD_W-1:0] hd;
    } cordic_t;

    // atan(2^-i) in radians Q.20, rounded to nearest.
    function automatic logic signed [Z_W-1:0] atan_q20(input logic [4:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 24'sd823550;
            5'd1:    v = 24'sd486170;
            5'd2:    v = 24'sd256879;
            5'd3:    v = 24'sd130396;
            5'd4:    v = 24'sd65451;
            5'd5:    v = 24'sd32757;
            5'd6:    v = 24'sd16383;
            5'd7:    v = 24'sd8192;
            5'd8:    v = 24'sd4096;
            5'd9:    v = 24'sd2048;
            5'd10:   v = 24'sd1024;
            5'd11:   v = 24'sd512;
            5'd12:   v = 24'sd256;
            5'd13:   v = 24'sd128;
            5'd14:   v = 24'sd64;
            5'd15:   v = 24'sd32;
            5'd16:   v = 24'sd16;
            5'd17:   v = 24'sd8;
            5'd18:   v = 24'sd4;
            5'd19:   v = 24'sd2;
            5'd20:   v = 24'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/go_to_goal_steering_core.sv =====
// Top level of the go-to-goal steering core: configuration registers, input
// stage with quadrant pre-rotation, CORDIC pipeline and back end.
// Depends on gtg_pkg, gtg_cordic_stage and gtg_post.
//
// Usage: each transfer on the s_ channel carries one robot pose (x, y and
// heading). The core forms the vector to the configured goal, finds its
// bearing and length with a pipelined vectoring CORDIC, and returns one
// result transfer on the m_ channel per pose: a clamped angular rate and a
// clamped linear speed, with m_tuser set when the robot is within the
// arrival tolerance (both commands are then zero).
// From input transfer to result valid a pose passes one input stage, one
// stage per CORDIC micro-rotation (16 by default) and four back-end stages.
// Throughput is one pose per cycle while m_tready is high. Every stage has
// its own valid bit and loads whenever it is empty or the stage after it
// moves on, so bubbles close up and a stalled receiver only halts the
// pipeline once every stage is full; nothing is lost or repeated.
// Configuration is written through cfg_we/cfg_index/cfg_wdata and must
// only change while no pose is in flight.
// The synchronous active-low reset empties the pipeline and restores the
// register defaults (goal at 1419, 1419; tolerance 26; gains 128; turn
// limit 2048; drive limit 256).
module go_to_goal_steering_core
    import gtg_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // pose_x [15:0], pose_y [31:16], heading [46:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // angular_rate [14:0], linear_speed [29:15]
    output logic        m_tuser,   // at_goal [0]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    localparam int NUM_ITER = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    logic signed [15:0] pose_x;
    logic signed [15:0] pose_y;
    logic signed [14:0] heading;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [XY_W-1:0] x_ext;
    logic signed [XY_W-1:0] y_ext;

    cordic_t st0_reg;
    cordic_t st0_next;
    logic    st0_valid_reg;

    cordic_t cor_data  [0:NUM_ITER];
    logic    cor_valid [0:NUM_ITER];
    logic    cor_ready [0:NUM_ITER];

    logic signed [14:0] angular_rate;
    logic [14:0]        linear_speed;
    logic               at_goal;

    // Register writes take effect at the edge where cfg_we is high; indexes
    // beyond the register list are ignored.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_GOAL_X:           cfg_next.goal_x           = $signed(cfg_wdata);
                REG_GOAL_Y:           cfg_next.goal_y           = $signed(cfg_wdata);
                REG_ARRIVE_TOLERANCE: cfg_next.arrive_tolerance = cfg_wdata[14:0];
                REG_TURN_GAIN:        cfg_next.turn_gain        = cfg_wdata[11:0];
                REG_TURN_LIMIT:       cfg_next.turn_limit       = cfg_wdata[13:0];
                REG_DRIVE_GAIN:       cfg_next.drive_gain       = cfg_wdata[11:0];
                REG_DRIVE_LIMIT:      cfg_next.drive_limit      = cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.goal_x           <= 16'sd1419;
            cfg_reg.goal_y           <= 16'sd1419;
            cfg_reg.arrive_tolerance <= 15'd26;
            cfg_reg.turn_gain        <= 12'd128;
            cfg_reg.turn_limit       <= 14'd2048;
            cfg_reg.drive_gain       <= 12'd128;
            cfg_reg.drive_limit      <= 15'd256;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Input stage: the vector to the goal gets eight guard bits, and a vector
    // in the left half-plane is turned through pi so that the CORDIC starts
    // with a non-negative x.
    assign pose_x  = $signed(s_tdata[15:0]);
    assign pose_y  = $signed(s_tdata[31:16]);
    assign heading = $signed(s_tdata[46:32]);

    always_comb begin
        dx    = 17'(cfg_reg.goal_x) - 17'(pose_x);
        dy    = 17'(cfg_reg.goal_y) - 17'(pose_y);
        x_ext = {{(XY_W-25){dx[16]}}, dx, 8'h00};
        y_ext = {{(XY_W-25){dy[16]}}, dy, 8'h00};
        st0_next.hd = heading;
        if (dx[16]) begin
            st0_next.x = -x_ext;
            st0_next.y = -y_ext;
            st0_next.z = dy[16] ? -ANG_PI_Q20 : ANG_PI_Q20;
        end else begin
            st0_next.x = x_ext;
            st0_next.y = y_ext;
            st0_next.z = '0;
        end
    end

    assign s_tready = !st0_valid_reg || cor_ready[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st0_valid_reg <= 1'b0;
        end else if (s_tready) begin
            st0_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            st0_reg <= st0_next;
        end
    end

    assign cor_data[0]  = st0_reg;
    assign cor_valid[0] = st0_valid_reg;

    // One registered micro-rotation per CORDIC iteration.
    for (genvar i = 0; i < NUM_ITER; i++) begin : g_cordic
        gtg_cordic_stage #(
            .STAGE (i)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (cor_valid[i]),
            .in_ready  (cor_ready[i]),
            .in_data   (cor_data[i]),
            .out_valid (cor_valid[i+1]),
            .out_ready (cor_ready[i+1]),
            .out_data  (cor_data[i+1])
        );
    end

    gtg_post u_post (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .in_valid     (cor_valid[NUM_ITER]),
        .in_ready     (cor_ready[NUM_ITER]),
        .in_data      (cor_data[NUM_ITER]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .angular_rate (angular_rate),
        .linear_speed (linear_speed),
        .at_goal      (at_goal)
    );

    assign m_tdata = {2'b00, linear_speed, angular_rate};
    assign m_tuser = at_goal;

endmodule

// ===== hw/rtl/gtg_cordic_stage.sv =====
// One registered micro-rotation of the vectoring CORDIC.
// Depends on gtg_pkg for the payload type and the arctangent table.
module gtg_cordic_stage
    import gtg_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  cordic_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output cordic_t out_data
);

    logic    valid_reg;
    cordic_t data_reg;
    cordic_t data_next;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic signed [Z_W-1:0]  ang;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        xs  = in_data.x >>> STAGE;
        ys  = in_data.y >>> STAGE;
        ang = atan_q20(5'(STAGE));
        data_next    = in_data;
        if (!in_data.y[XY_W-1]) begin
            data_next.x = in_data.x + ys;
            data_next.y = in_data.y - xs;
            data_next.z = in_data.z + ang;
        end else begin
            data_next.x = in_data.x - ys;
            data_next.y = in_data.y + xs;
            data_next.z = in_data.z - ang;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== hw/rtl/gtg_post.sv =====
// Back end of the steering core: distance scaling, bearing rounding, heading
// error wrap, gain multiplies and clamps over four stages. Depends on gtg_pkg.
module gtg_post
    import gtg_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  cordic_t            in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [14:0] angular_rate,
    output logic [14:0]        linear_speed,
    output logic               at_goal
);

    localparam int PROD_W   = XY_W + 18;
    localparam int DIST_W   = 20;
    localparam int ERR_W    = 18;
    localparam int RPROD_W  = ERR_W + 13;
    localparam int SPROD_W  = DIST_W + 13;
    localparam int RATE_W   = RPROD_W - 8;
    localparam int SPEED_W  = SPROD_W - 8;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    // Stage 1: distance product and rounded bearing.
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [BEAR_W-1:0] bear_reg;
    logic signed [HD_W-1:0]   hd1_reg;
    logic [Z_W-1:0]           z_round;
    // Stage 2: distance and wrapped heading error.
    logic signed [DIST_W-1:0] dist2_reg;
    logic signed [ERR_W-1:0]  err_reg;
    logic [PROD_W-1:0]        prod_round;
    logic signed [ERR_W-1:0]  err_raw;
    logic signed [ERR_W-1:0]  err_next;
    // Stage 3: gain products and the arrival test.
    logic signed [RPROD_W-1:0] rprod_reg;
    logic signed [SPROD_W-1:0] sprod_reg;
    logic                      arrive_reg;
    // Stage 4: output register.
    logic signed [14:0]        rate_reg;
    logic [14:0]               speed_reg;
    logic                      goal_reg;
    logic [RPROD_W-1:0]        rprod_round;
    logic [SPROD_W-1:0]        sprod_round;
    logic signed [RATE_W-1:0]  rate_full;
    logic signed [SPEED_W-1:0] speed_full;
    logic signed [RATE_W-1:0]  rate_lim;
    logic signed [SPEED_W-1:0] speed_lim;
    logic signed [14:0]        rate_next;
    logic [14:0]               speed_next;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign out_valid    = v4_reg;
    assign angular_rate = rate_reg;
    assign linear_speed = speed_reg;
    assign at_goal      = goal_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    assign z_round = in_data.z + Z_W'(128);

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            prod_reg <= PROD_W'(in_data.x * INV_GAIN_Q16);
            bear_reg <= $signed(z_round[Z_W-1:8]);
            hd1_reg  <= in_data.hd;
        end
    end

    always_comb begin
        prod_round = prod_reg + (PROD_W'(1) << 23);
        err_raw    = ERR_W'(bear_reg) - ERR_W'(hd1_reg);
        if (err_raw > ERR_W'(PI_Q12)) begin
            err_next = err_raw - ERR_W'(TWO_PI_Q12);
        end else if (err_raw < -ERR_W'(PI_Q12)) begin
            err_next = err_raw + ERR_W'(TWO_PI_Q12);
        end else begin
            err_next = err_raw;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            dist2_reg <= $signed(prod_round[24 +: DIST_W]);
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            rprod_reg  <= RPROD_W'(err_reg * $signed({1'b0, cfg.turn_gain}));
            sprod_reg  <= SPROD_W'(dist2_reg * $signed({1'b0, cfg.drive_gain}));
            arrive_reg <= dist2_reg <= $signed({{(DIST_W-15){1'b0}}, cfg.arrive_tolerance});
        end
    end

    always_comb begin
        rprod_round = rprod_reg + RPROD_W'(128);
        sprod_round = sprod_reg + SPROD_W'(128);
        rate_full   = $signed(rprod_round[RPROD_W-1:8]);
        speed_full  = $signed(sprod_round[SPROD_W-1:8]);
        rate_lim    = $signed({{(RATE_W-14){1'b0}}, cfg.turn_limit});
        speed_lim   = $signed({{(SPEED_W-15){1'b0}}, cfg.drive_limit});
        if (rate_full > rate_lim) begin
            rate_next = 15'(rate_lim);
        end else if (rate_full < -rate_lim) begin
            rate_next = 15'(-rate_lim);
        end else begin
            rate_next = 15'(rate_full);
        end
        if (speed_full > speed_lim) begin
            speed_next = 15'(speed_lim);
        end else if (speed_full < 0) begin
            speed_next = '0;
        end else begin
            speed_next = 15'(speed_full);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4 && v3_reg) begin
            if (arrive_reg) begin
                rate_reg  <= '0;
                speed_reg <= '0;
                goal_reg  <= 1'b1;
            end else begin
                rate_reg  <= rate_next;
                speed_reg <= speed_next;
                goal_reg  <= 1'b0;
            end
        end
    end

endmodule

// ===== hw/rtl/gtg_checker.sv =====
// Port-level checker for go_to_goal_steering_core, bound to the top level.
// Depends on go_to_goal_steering_core_defines.svh for the assertion macros.
`include "go_to_goal_steering_core_defines.svh"

module gtg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    // A held result keeps its valid.
    `GTG_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    // A held result keeps its payload.
    `GTG_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // Arrival forces both commands to zero.
    `GTG_ASSERT_NOW(a_goal_zero, aclk, aresetn, m_tvalid && m_tuser, m_tdata == 32'd0, "commands not zero at goal")

    // Reset empties the pipeline.
    `GTG_ASSERT_ALWAYS_NEXT(a_reset_empty, aclk, !aresetn, !m_tvalid, "result valid after reset")

endmodule

bind go_to_goal_steering_core gtg_checker u_gtg_checker (.*);
